// ===== design/budgeted_residency_manager_defines.svh =====
// assertion macros for the residency manager checker
// expects clk and rst_n in the scope of use
`ifndef BUDGETED_RESIDENCY_MANAGER_DEFINES_SVH
`define BUDGETED_RESIDENCY_MANAGER_DEFINES_SVH

// same-cycle implication
`define BRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("residency manager check failed");

// next-cycle implication
`define BRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("residency manager check failed");

`endif

// ===== design/brm_pkg.sv =====
// types, codes and constants for the budgeted residency manager
// no dependencies
package brm_pkg;

    localparam int MAX_SETS_DEF = 32;
    localparam int MB_SHIFT     = 20;
    localparam int IN_IDX_W     = 5;
    localparam int SIZE_W       = 36;
    localparam int FRAME_W      = 32;
    localparam int RB_W         = 41;
    localparam int NR_W         = 6;
    localparam int OPS_W        = 6;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_SEEN     = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_TICK     = 2'd3
    } brm_op_t;

    typedef enum logic [1:0] {
        KIND_STREAM = 2'd0,
        KIND_EVICT  = 2'd1,
        KIND_STATUS = 2'd2
    } brm_kind_t;

    localparam logic [1:0] ST_RESIDENT  = 2'd0;
    localparam logic [1:0] ST_EVICTED   = 2'd1;
    localparam logic [1:0] ST_STREAMING = 2'd2;

    typedef enum logic [PADDR_W-1:0] {
        REG_ENABLED    = 5'd0,
        REG_BUDGET     = 5'd4,
        REG_COLD       = 5'd8,
        REG_MAX_OPS    = 5'd12,
        REG_MAX_STREAM = 5'd16
    } brm_reg_addr_t;

    typedef struct packed {
        logic        enabled;
        logic [13:0] budget_mb;
        logic [11:0] cold_frames;
        logic [5:0]  max_ops;
        logic [8:0]  max_stream_mb;
    } brm_cfg_t;

    typedef struct packed {
        logic [1:0]         residency;
        logic               failed;
        logic [FRAME_W-1:0] last_seen;
        logic [SIZE_W-1:0]  size;
    } brm_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_RD,
        S_MOD_WR,
        S_STR_RD,
        S_STR_CHK,
        S_TOT_RD,
        S_TOT_ACC,
        S_EV_RD,
        S_EV_CHK,
        S_EV_WR,
        S_STATUS
    } brm_state_t;

endpackage

// ===== design/brm_ram.sv =====
// set table memory: one write port, one read port with registered data
// depends on brm_pkg
module brm_ram
    import brm_pkg::*;
#(
    parameter int DEPTH = MAX_SETS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  brm_entry_t               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output brm_entry_t               rdata
);

    brm_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/brm_cfg.sv =====
// apb configuration registers
// depends on brm_pkg
module brm_cfg
    import brm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output brm_cfg_t           cfg
);

    brm_cfg_t cfg_reg;
    logic     wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled       <= 1'b1;
            cfg_reg.budget_mb     <= 14'd1024;
            cfg_reg.cold_frames   <= 12'd300;
            cfg_reg.max_ops       <= 6'd4;
            cfg_reg.max_stream_mb <= 9'd64;
        end
        else if (wr_en)
        begin
            priority case (paddr)
                REG_ENABLED:    cfg_reg.enabled       <= pwdata[0];
                REG_BUDGET:     cfg_reg.budget_mb     <= pwdata[13:0];
                REG_COLD:       cfg_reg.cold_frames   <= pwdata[11:0];
                REG_MAX_OPS:    cfg_reg.max_ops       <= pwdata[5:0];
                REG_MAX_STREAM: cfg_reg.max_stream_mb <= pwdata[8:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        priority case (paddr)
            REG_ENABLED:    prdata = PDATA_W'(cfg_reg.enabled);
            REG_BUDGET:     prdata = PDATA_W'(cfg_reg.budget_mb);
            REG_COLD:       prdata = PDATA_W'(cfg_reg.cold_frames);
            REG_MAX_OPS:    prdata = PDATA_W'(cfg_reg.max_ops);
            REG_MAX_STREAM: prdata = PDATA_W'(cfg_reg.max_stream_mb);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== design/brm_ctrl.sv =====
// sequencer: read-modify-write passes over the set table and result register
// depends on brm_pkg and brm_ram
module brm_ctrl
    import brm_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  brm_cfg_t            cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [IN_IDX_W-1:0] set_index,
    input  logic [SIZE_W-1:0]   set_bytes,
    input  logic                completion_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic [IN_IDX_W-1:0] set_index_res,
    output logic [RB_W-1:0]     resident_bytes,
    output logic [NR_W-1:0]     nonresident_count,
    output logic                error,
    output logic                last
);

    localparam int IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int CNT_W = $clog2(MAX_SETS + 1);
    localparam int EXT_W = IN_IDX_W + CNT_W;
    localparam int SUM_W = SIZE_W + CNT_W;

    brm_state_t state_reg, state_next;

    // latched request
    brm_op_t               op_reg;
    logic [IN_IDX_W-1:0]   idx_reg;
    logic [SIZE_W-1:0]     bytes_reg;
    logic                  ok_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [OPS_W-1:0]      ops_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      issued_reg;
    logic [CNT_W-1:0]      nonres_reg;
    logic [CNT_W-1:0]      assigned_reg;
    logic                  err_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      best_idx_reg;
    logic [FRAME_W-1:0]    best_age_reg;
    brm_entry_t            best_reg;

    logic                  out_valid_reg;
    brm_kind_t             kind_reg;
    logic [IN_IDX_W-1:0]   idx_res_reg;
    logic [RB_W-1:0]       rb_reg;
    logic [NR_W-1:0]       nr_reg;
    logic                  err_out_reg;
    logic                  last_reg;

    // memory ports
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    brm_entry_t            ram_wdata, rd;

    logic                  out_free, i_end, full, idx_ok, str_stop, cand_str;
    logic                  cand_ev, better, over, ev_left, emit, i_clear, i_inc;
    logic [EXT_W-1:0]      idx_ext, count_ext, i_ext, best_ext, assigned_ext;
    logic [FRAME_W-1:0]    age;
    logic [SUM_W-1:0]      max_bytes, budget, sum_after;
    brm_kind_t             emit_kind;
    logic [IN_IDX_W-1:0]   emit_idx;

    brm_ram #(.DEPTH(MAX_SETS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    assign out_free     = !out_valid_reg || out_ready;
    assign i_end        = i_reg >= count_reg;
    assign full         = count_reg == CNT_W'(MAX_SETS);
    assign idx_ext      = EXT_W'(idx_reg);
    assign count_ext    = EXT_W'(count_reg);
    assign i_ext        = EXT_W'(i_reg);
    assign best_ext     = EXT_W'(best_idx_reg);
    assign assigned_ext = EXT_W'(assigned_reg);
    assign idx_ok       = idx_ext < count_ext;
    assign max_bytes    = SUM_W'(cfg.max_stream_mb) << MB_SHIFT;
    assign budget       = SUM_W'(cfg.budget_mb) << MB_SHIFT;
    assign str_stop     = (ops_reg >= cfg.max_ops) || (issued_reg >= max_bytes);
    assign cand_str     = (rd.residency == ST_EVICTED) && !rd.failed
                          && (rd.last_seen == frame_reg);
    assign age          = frame_reg - rd.last_seen;
    assign cand_ev      = (rd.residency == ST_RESIDENT) && (age >= FRAME_W'(cfg.cold_frames));
    assign better       = !found_reg || (age > best_age_reg);
    assign over         = cfg.enabled && (sum_reg > budget);
    assign sum_after    = sum_reg - SUM_W'(best_reg.size);
    assign ev_left      = sum_after > budget;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = (brm_op_t'(op) == OP_TICK) ? S_STR_RD : S_MOD_RD;
                end
            S_MOD_RD:
                state_next = (op_reg != OP_REGISTER && idx_ok) ? S_MOD_WR : S_TOT_RD;
            S_MOD_WR:
                state_next = S_TOT_RD;
            S_STR_RD:
                state_next = i_end ? S_TOT_RD : S_STR_CHK;
            S_STR_CHK:
                if (str_stop)
                begin
                    state_next = S_TOT_RD;
                end
                else if (!cand_str || out_free)
                begin
                    state_next = S_STR_RD;
                end
            S_TOT_RD:
                if (!i_end)
                begin
                    state_next = S_TOT_ACC;
                end
                else
                begin
                    state_next = (op_reg == OP_TICK && over) ? S_EV_RD : S_STATUS;
                end
            S_TOT_ACC:
                state_next = S_TOT_RD;
            S_EV_RD:
                if (!i_end)
                begin
                    state_next = S_EV_CHK;
                end
                else
                begin
                    state_next = found_reg ? S_EV_WR : S_STATUS;
                end
            S_EV_CHK:
                state_next = S_EV_RD;
            S_EV_WR:
                if (out_free)
                begin
                    state_next = ev_left ? S_EV_RD : S_STATUS;
                end
            S_STATUS:
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // memory controls and result emission
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = i_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = i_reg[IDX_W-1:0];
        ram_wdata = rd;
        emit      = 1'b0;
        emit_kind = KIND_STATUS;
        emit_idx  = '0;
        unique case (state_reg)
            S_MOD_RD:
                if (op_reg == OP_REGISTER)
                begin
                    ram_we              = !full;
                    ram_waddr           = count_reg[IDX_W-1:0];
                    ram_wdata.residency = ST_RESIDENT;
                    ram_wdata.failed    = 1'b0;
                    ram_wdata.last_seen = frame_reg;
                    ram_wdata.size      = bytes_reg;
                end
                else
                begin
                    ram_re    = idx_ok;
                    ram_raddr = idx_ext[IDX_W-1:0];
                end
            S_MOD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_ext[IDX_W-1:0];
                if (op_reg == OP_SEEN)
                begin
                    ram_wdata.last_seen = frame_reg;
                end
                else if (ok_reg)
                begin
                    ram_wdata.residency = ST_RESIDENT;
                end
                else
                begin
                    ram_wdata.residency = ST_EVICTED;
                    ram_wdata.failed    = 1'b1;
                end
            end
            S_STR_RD, S_TOT_RD, S_EV_RD:
                ram_re = !i_end;
            S_STR_CHK:
                if (!str_stop && cand_str && out_free)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.residency = ST_STREAMING;
                    emit                = 1'b1;
                    emit_kind           = KIND_STREAM;
                    emit_idx            = i_ext[IN_IDX_W-1:0];
                end
            S_EV_WR:
                if (out_free)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = best_idx_reg[IDX_W-1:0];
                    ram_wdata           = best_reg;
                    ram_wdata.residency = ST_EVICTED;
                    emit                = 1'b1;
                    emit_kind           = KIND_EVICT;
                    emit_idx            = best_ext[IN_IDX_W-1:0];
                end
            S_STATUS:
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_STATUS;
                    emit_idx  = assigned_ext[IN_IDX_W-1:0];
                end
            default:
                ;
        endcase
    end

    // a pass restarts at index zero when entered from another phase
    assign i_clear = (state_reg == S_IDLE)
                     || (state_next == S_TOT_RD && state_reg != S_TOT_ACC)
                     || (state_next == S_EV_RD && state_reg != S_EV_CHK);
    assign i_inc   = (state_reg == S_TOT_ACC) || (state_reg == S_EV_CHK)
                     || (state_reg == S_STR_CHK && state_next == S_STR_RD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ops_reg       <= '0;
            frame_reg     <= '0;
            i_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (i_clear)
            begin
                i_reg <= '0;
            end
            else if (i_inc)
            begin
                i_reg <= i_reg + 1'b1;
            end

            if (state_reg == S_MOD_RD && op_reg == OP_REGISTER && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (state_reg == S_MOD_WR && op_reg == OP_COMPLETE && ops_reg != '0)
            begin
                ops_reg <= ops_reg - 1'b1;
            end
            else if (state_reg == S_STR_CHK && emit)
            begin
                ops_reg <= ops_reg + 1'b1;
            end

            if (state_reg == S_STATUS && out_free && op_reg == OP_TICK)
            begin
                frame_reg <= frame_reg + 1'b1;
            end

            if (state_next == S_EV_RD && state_reg != S_EV_CHK)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == S_EV_CHK && cand_ev && better)
            begin
                found_reg <= 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            op_reg       <= brm_op_t'(op);
            idx_reg      <= set_index;
            bytes_reg    <= set_bytes;
            ok_reg       <= completion_ok;
            issued_reg   <= '0;
            err_reg      <= 1'b0;
            assigned_reg <= '0;
        end

        if (state_reg == S_MOD_RD && op_reg == OP_REGISTER)
        begin
            err_reg      <= full;
            assigned_reg <= full ? '0 : count_reg;
        end

        if (state_reg == S_STR_CHK && emit)
        begin
            issued_reg <= issued_reg + SUM_W'(rd.size);
        end

        if (state_next == S_TOT_RD && state_reg != S_TOT_ACC)
        begin
            sum_reg    <= '0;
            nonres_reg <= '0;
        end
        else if (state_reg == S_TOT_ACC)
        begin
            if (rd.residency == ST_RESIDENT)
            begin
                sum_reg <= sum_reg + SUM_W'(rd.size);
            end
            else
            begin
                nonres_reg <= nonres_reg + 1'b1;
            end
        end
        else if (state_reg == S_EV_WR && out_free)
        begin
            sum_reg    <= sum_after;
            nonres_reg <= nonres_reg + 1'b1;
        end

        if (state_reg == S_EV_CHK && cand_ev && better)
        begin
            best_idx_reg <= i_reg;
            best_age_reg <= age;
            best_reg     <= rd;
        end

        if (emit)
        begin
            kind_reg    <= emit_kind;
            idx_res_reg <= emit_idx;
            last_reg    <= emit_kind == KIND_STATUS;
            err_out_reg <= (emit_kind == KIND_STATUS) && err_reg;
            rb_reg      <= (emit_kind == KIND_STATUS) ? RB_W'(sum_reg) : '0;
            nr_reg      <= (emit_kind == KIND_STATUS) ? NR_W'(nonres_reg) : '0;
        end
    end

    assign in_ready          = state_reg == S_IDLE;
    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign set_index_res     = idx_res_reg;
    assign resident_bytes    = rb_reg;
    assign nonresident_count = nr_reg;
    assign error             = err_out_reg;
    assign last              = last_reg;

endmodule

// ===== design/budgeted_residency_manager.sv =====
// a non-tick request makes any table update and one totals pass before its status result
// a tick makes one stream-in pass, one totals pass, then one scan pass per eviction
// before its status result; each pass reads the table one entry at a time
// one request at a time; in_ready is high only between requests
// reset: asynchronous, active low; clears counts and frame number, restores config defaults
// table entries are written on registration and need no clearing
module budgeted_residency_manager
    import brm_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [IN_IDX_W-1:0] set_index,
    input  logic [SIZE_W-1:0]   set_bytes,
    input  logic                completion_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic [IN_IDX_W-1:0] set_index_res,
    output logic [RB_W-1:0]     resident_bytes,
    output logic [NR_W-1:0]     nonresident_count,
    output logic                error,
    output logic                last
);

    brm_cfg_t cfg;

    assign pready = 1'b1;

    brm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    brm_ctrl #(.MAX_SETS(MAX_SETS)) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .set_index         (set_index),
        .set_bytes         (set_bytes),
        .completion_ok     (completion_ok),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .set_index_res     (set_index_res),
        .resident_bytes    (resident_bytes),
        .nonresident_count (nonresident_count),
        .error             (error),
        .last              (last)
    );

endmodule

// ===== design/brm_checker.sv =====
// port-level checks for the budgeted residency manager, bound to the top level
// depends on brm_pkg and budgeted_residency_manager_defines.svh
`include "budgeted_residency_manager_defines.svh"

module brm_checker
    import brm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          kind,
    input logic [IN_IDX_W-1:0] set_index_res,
    input logic [RB_W-1:0]     resident_bytes,
    input logic [NR_W-1:0]     nonresident_count,
    input logic                error,
    input logic                last
);

    // a stalled result holds
    `BRM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(set_index_res) && $stable(last))

    // status and last go together
    `BRM_ASSERT_IMP(a_last_status, out_valid, last == (kind == KIND_STATUS))

    // stream and eviction results carry no totals or error
    `BRM_ASSERT_IMP(a_plain_fields, out_valid && kind != KIND_STATUS, resident_bytes == '0 && nonresident_count == '0 && !error)

    // one request in work at a time
    `BRM_ASSERT_NXT(a_one_request, in_valid && in_ready, !in_ready)

endmodule

bind budgeted_residency_manager brm_checker u_brm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .kind              (kind),
    .set_index_res     (set_index_res),
    .resident_bytes    (resident_bytes),
    .nonresident_count (nonresident_count),
    .error             (error),
    .last              (last)
);

// ===== tb/sv/tb_budgeted_residency_manager.sv =====
// self-checking testbench for the budgeted residency manager
// depends on brm_pkg and the budgeted_residency_manager rtl
`timescale 1ns / 1ps

module tb_budgeted_residency_manager;
    import brm_pkg::*;

    localparam int SETS        = 32;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int IDLE_PCT    = 32;

    typedef struct {
        logic [1:0]      kind;
        logic [4:0]      idx;
        logic [RB_W-1:0] rb;
        logic [NR_W-1:0] nr;
        logic            err;
        logic            last;
    } result_t;

    typedef struct {
        brm_op_t         op;
        logic [4:0]      idx;
        logic [35:0]     bytes;
        logic            ok;
        bit              typed;
        logic [4:0]      e_idx;
        logic [RB_W-1:0] e_rb;
        logic [NR_W-1:0] e_nr;
        logic            e_err;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          op;
    logic [IN_IDX_W-1:0] set_index;
    logic [SIZE_W-1:0]   set_bytes;
    logic                completion_ok;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          kind;
    logic [IN_IDX_W-1:0] set_index_res;
    logic [RB_W-1:0]     resident_bytes;
    logic [NR_W-1:0]     nonresident_count;
    logic                error;
    logic                last;

    budgeted_residency_manager dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .set_index(set_index),
        .set_bytes(set_bytes), .completion_ok(completion_ok),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .set_index_res(set_index_res), .resident_bytes(resident_bytes),
        .nonresident_count(nonresident_count), .error(error), .last(last)
    );

    // shadow of the block's table and registers
    logic [1:0]  m_res    [SETS];
    logic        m_failed [SETS];
    logic [31:0] m_seen   [SETS];
    logic [35:0] m_size   [SETS];
    int          m_count;
    logic [5:0]  m_ops;
    logic [31:0] m_frame;
    logic        c_enabled;
    logic [13:0] c_budget;
    logic [11:0] c_cold;
    logic [5:0]  c_max_ops;
    logic [8:0]  c_max_stream;

    result_t  pending_q[$];
    dir_row_t dir_q[$];
    int       fail_count;
    int       cycle_count;
    int       hold_cycles;
    bit       calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("budgeted_residency_manager test failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    task automatic push_result(input logic [1:0] k, input logic [4:0] i,
                               input logic [63:0] rb, input logic [5:0] nr,
                               input logic e, input logic l);
        result_t r;
        r.kind = k;
        r.idx  = i;
        r.rb   = rb[RB_W-1:0];
        r.nr   = nr;
        r.err  = e;
        r.last = l;
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic resident_totals(output logic [63:0] sum, output logic [5:0] cnt);
        sum = 64'd0;
        cnt = 6'd0;
        for (int i = 0; i < m_count; i++)
        begin
            if (m_res[i] == ST_RESIDENT)
                sum += {28'd0, m_size[i]};
            else
                cnt++;
        end
    endtask

    task automatic predict_tick();
        logic [63:0] issued;
        logic [63:0] max_bytes;
        logic [63:0] budget;
        logic [63:0] resident;
        logic [5:0]  nonres;
        bit          taken [SETS];
        int          best;
        logic [31:0] best_age;
        logic [31:0] age;
        issued    = 64'd0;
        max_bytes = {55'd0, c_max_stream} << MB_SHIFT;
        budget    = {50'd0, c_budget} << MB_SHIFT;
        for (int i = 0; i < m_count; i++)
        begin
            if (m_ops >= c_max_ops || issued >= max_bytes)
                break;
            if (m_res[i] == ST_EVICTED && !m_failed[i] && m_seen[i] == m_frame)
            begin
                m_res[i] = ST_STREAMING;
                m_ops    = m_ops + 6'd1;
                issued  += {28'd0, m_size[i]};
                push_result(KIND_STREAM, i[4:0], 64'd0, 6'd0, 1'b0, 1'b0);
            end
        end
        resident_totals(resident, nonres);
        if (c_enabled && resident > budget)
        begin
            for (int i = 0; i < SETS; i++)
                taken[i] = 1'b0;
            while (resident > budget)
            begin
                best     = -1;
                best_age = 32'd0;
                for (int i = 0; i < m_count; i++)
                begin
                    age = m_frame - m_seen[i];
                    if (taken[i] || m_res[i] != ST_RESIDENT || age < {20'd0, c_cold})
                        continue;
                    if (best < 0 || age > best_age)
                    begin
                        best     = i;
                        best_age = age;
                    end
                end
                if (best < 0)
                    break;
                taken[best] = 1'b1;
                m_res[best] = ST_EVICTED;
                resident   -= {28'd0, m_size[best]};
                push_result(KIND_EVICT, best[4:0], 64'd0, 6'd0, 1'b0, 1'b0);
            end
        end
        resident_totals(resident, nonres);
        m_frame = m_frame + 32'd1;
        push_result(KIND_STATUS, 5'd0, resident, nonres, 1'b0, 1'b1);
    endtask

    task automatic predict_request(input brm_op_t o, input logic [4:0] i,
                                   input logic [35:0] b, input logic ok);
        logic [63:0] resident;
        logic [5:0]  nonres;
        logic [4:0]  assigned;
        logic        err;
        assigned = 5'd0;
        err      = 1'b0;
        if (o == OP_TICK)
            predict_tick();
        else
        begin
            if (o == OP_REGISTER)
            begin
                if (m_count >= SETS)
                    err = 1'b1;
                else
                begin
                    m_res[m_count]    = ST_RESIDENT;
                    m_failed[m_count] = 1'b0;
                    m_seen[m_count]   = m_frame;
                    m_size[m_count]   = b;
                    assigned          = m_count[4:0];
                    m_count++;
                end
            end
            else if (int'(i) < m_count)
            begin
                if (o == OP_SEEN)
                    m_seen[i] = m_frame;
                else
                begin
                    if (m_ops > 6'd0)
                        m_ops--;
                    if (ok)
                        m_res[i] = ST_RESIDENT;
                    else
                    begin
                        m_res[i]    = ST_EVICTED;
                        m_failed[i] = 1'b1;
                    end
                end
            end
            resident_totals(resident, nonres);
            push_result(KIND_STATUS, assigned, resident, nonres, err, 1'b1);
        end
    endtask

    task automatic apb_write(input brm_reg_addr_t a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (a)
            REG_ENABLED:    c_enabled    = d[0];
            REG_BUDGET:     c_budget     = d[13:0];
            REG_COLD:       c_cold       = d[11:0];
            REG_MAX_OPS:    c_max_ops    = d[5:0];
            REG_MAX_STREAM: c_max_stream = d[8:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic en, input int budget, input int cold,
                                input int ops, input int stream);
        apb_write(REG_ENABLED, {31'd0, en});
        apb_write(REG_BUDGET, budget);
        apb_write(REG_COLD, cold);
        apb_write(REG_MAX_OPS, ops);
        apb_write(REG_MAX_STREAM, stream);
    endtask

    task automatic send_request(input brm_op_t o, input logic [4:0] i,
                                input logic [35:0] b, input logic ok);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        set_index     <= i;
        set_bytes     <= b;
        completion_ok <= ok;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(o, i, b, ok);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_row(input brm_op_t o, input logic [4:0] i, input logic [35:0] b,
                           input logic ok, input bit t, input logic [4:0] ei,
                           input logic [RB_W-1:0] erb, input logic [NR_W-1:0] enr,
                           input logic ee);
        dir_row_t r;
        r.op = o; r.idx = i; r.bytes = b; r.ok = ok; r.typed = t;
        r.e_idx = ei; r.e_rb = erb; r.e_nr = enr; r.e_err = ee;
        dir_q.insert(dir_q.size(), r);
    endtask

    // row checked against the predictor only
    task automatic add_plain(input brm_op_t o, input logic [4:0] i, input logic [35:0] b,
                             input logic ok);
        add_row(o, i, b, ok, 1'b0, 5'd0, 41'd0, 6'd0, 1'b0);
    endtask

    function automatic logic [35:0] random_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 36'd0;
        if (pick < 25)
            return 36'({$urandom, $urandom} & 64'hF_FFFF_FFFF);
        return 36'(($urandom_range(24, 1) << 20) | ($urandom & 32'hFFFFF));
    endfunction

    task automatic random_request();
        int          pick;
        int          streaming [$];
        logic [4:0]  i;
        brm_op_t     o;
        pick = $urandom_range(99);
        i    = 5'($urandom_range(31));
        if (pick < ((m_count < SETS) ? 18 : 3))
            o = OP_REGISTER;
        else if (pick < 45)
        begin
            o = OP_SEEN;
            if (m_count > 0 && $urandom_range(9) < 8)
                i = 5'($urandom_range(m_count - 1));
        end
        else if (pick < 60)
        begin
            o = OP_COMPLETE;
            for (int k = 0; k < m_count; k++)
                if (m_res[k] == ST_STREAMING)
                    streaming.insert(streaming.size(), k);
            if (streaming.size() > 0 && $urandom_range(9) < 8)
                i = 5'(streaming[$urandom_range(streaming.size() - 1)]);
        end
        else
            o = OP_TICK;
        send_request(o, i, random_size(), $urandom_range(9) < 7);
    endtask

    // result side: check accepted results, then pick next ready
    initial
    begin
        result_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                    report_mismatch("unexpected result kind", 64'(kind), 64'd0);
                else
                begin
                    want = pending_q[0];
                    pending_q.delete(0);
                    if (kind !== want.kind)
                        report_mismatch("kind", 64'(kind), 64'(want.kind));
                    if (set_index_res !== want.idx)
                        report_mismatch("set_index_res", 64'(set_index_res),
                                        64'(want.idx));
                    if (resident_bytes !== want.rb)
                        report_mismatch("resident_bytes", 64'(resident_bytes),
                                        64'(want.rb));
                    if (nonresident_count !== want.nr)
                        report_mismatch("nonresident_count", 64'(nonresident_count),
                                        64'(want.nr));
                    if (error !== want.err)
                        report_mismatch("error", 64'(error), 64'(want.err));
                    if (last !== want.last)
                        report_mismatch("last", 64'(last), 64'(want.last));
                end
            end
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        dir_row_t r;
        fail_count    = 0;
        hold_cycles   = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        op            = OP_REGISTER;
        set_index     = '0;
        set_bytes     = '0;
        completion_ok = 1'b0;
        m_count       = 0;
        m_ops         = 6'd0;
        m_frame       = 32'd0;
        c_enabled     = 1'b1;
        c_budget      = 14'd1024;
        c_cold        = 12'd300;
        c_max_ops     = 6'd4;
        c_max_stream  = 9'd64;
        for (int k = 0; k < SETS; k++)
        begin
            m_res[k] = ST_RESIDENT; m_failed[k] = 1'b0; m_seen[k] = 32'd0; m_size[k] = 36'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unregistered indexes, widest and zero sizes, stray completions
        add_row(OP_TICK,     5'd0,  36'd0, 1'b0, 1'b1, 5'd0, 41'd0, 6'd0, 1'b0);
        add_row(OP_SEEN,     5'd5,  36'd0, 1'b0, 1'b1, 5'd0, 41'd0, 6'd0, 1'b0);
        add_row(OP_COMPLETE, 5'd31, 36'd0, 1'b0, 1'b1, 5'd0, 41'd0, 6'd0, 1'b0);
        add_row(OP_REGISTER, 5'd31, 36'hF_FFFF_FFFF, 1'b1, 1'b1, 5'd0,
                41'hF_FFFF_FFFF, 6'd0, 1'b0);
        add_row(OP_REGISTER, 5'd0,  36'd0, 1'b0, 1'b1, 5'd1, 41'hF_FFFF_FFFF, 6'd0, 1'b0);
        add_plain(OP_REGISTER, 5'd3,  36'h0_0300_0000, 1'b0);
        add_plain(OP_SEEN,     5'd0,  36'd0, 1'b0);
        add_plain(OP_TICK,     5'd0,  36'd0, 1'b0);
        add_plain(OP_COMPLETE, 5'd1,  36'd0, 1'b0);
        add_plain(OP_COMPLETE, 5'd2,  36'd0, 1'b1);
        add_plain(OP_SEEN,     5'd1,  36'd0, 1'b0);
        add_plain(OP_TICK,     5'd0,  36'd0, 1'b0);
        add_plain(OP_COMPLETE, 5'd1,  36'd0, 1'b1);
        add_plain(OP_REGISTER, 5'd0,  36'h0_0000_1234, 1'b0);
        add_plain(OP_SEEN,     5'd31, 36'd0, 1'b0);
        add_plain(OP_COMPLETE, 5'd0,  36'd0, 1'b0);
        add_plain(OP_SEEN,     5'd0,  36'd0, 1'b0);
        add_plain(OP_TICK,     5'd0,  36'd0, 1'b0);
        // fill the table, then one registration too many
        for (int k = 0; k < SETS - 4; k++)
            add_plain(OP_REGISTER, 5'd0, 36'h0_0010_0000, 1'b0);
        add_plain(OP_REGISTER, 5'd0, 36'h0_0010_0000, 1'b0);
        foreach (dir_q[n])
        begin
            r = dir_q[n];
            send_request(r.op, r.idx, r.bytes, r.ok);
            if (r.typed)
            begin
                pending_q[$].idx = r.e_idx;
                pending_q[$].rb  = r.e_rb;
                pending_q[$].nr  = r.e_nr;
                pending_q[$].err = r.e_err;
            end
        end
        drain();

        // tightest limits: one op in flight, smallest budget and stream allowance
        write_config(1'b1, 64, 30, 1, 4);
        repeat (30) random_request();
        drain();

        // widest limits, eviction off, no idling on either side
        calm = 1'b1;
        write_config(1'b0, 8192, 3000, 32, 256);
        repeat (25) random_request();
        drain();
        calm = 1'b0;

        // long receiver stall while requests keep coming
        write_config(1'b1, 100, 30, 32, 256);
        hold_cycles = 800;
        repeat (30) random_request();
        drain();

        write_config(1'($urandom_range(1)), $urandom_range(8192, 64), $urandom_range(60, 30),
                     $urandom_range(32, 1), $urandom_range(256, 4));
        repeat (30) random_request();
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("budgeted_residency_manager test passed");
        else
            $display("budgeted_residency_manager test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/brm_pkg.sv
design/brm_ram.sv
design/brm_cfg.sv
design/brm_ctrl.sv
design/budgeted_residency_manager.sv
design/brm_checker.sv
tb/sv/tb_budgeted_residency_manager.sv
